// ----- sv/tsmn_pkg.sv -----
// ----------------------------------------------------------------------------
// tsmn_pkg: shared types and constants
// Widths of the fixed word fields, register indexes, sequencer states and the
// request and response bundles of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tsmn_pkg;

  // Fixed field widths.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ValueW   = 24;
  localparam int unsigned FpvW     = 7;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Divider numerator: a sample times 100 in Q.16, plus rounding, fits 40 bits.
  localparam int unsigned NumW     = 40;
  localparam int unsigned ProdW    = FracW + ValueW;
  localparam int unsigned DivCntW  = 5;

  localparam logic [ValueW-1:0]  ValueMax     = '1;
  localparam logic [NumW-1:0]    PercentScale = NumW'(100);
  localparam logic [DivCntW-1:0] DivSteps     = DivCntW'(ValueW);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAMES    = 2'd0,
    CFG_NORM_MODE = 2'd1,
    CFG_THR_FRAC  = 2'd2,
    CFG_THR_ABS   = 2'd3
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_DIV,
    ST_MEAN_OUT,
    ST_THR_MUL,
    ST_THR_CMP,
    ST_FRM_RD,
    ST_FRM_LD,
    ST_FRM_DIV,
    ST_FRM_OUT
  } seq_state_e;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [NumW-1:0]   num;
    logic [ValueW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/tsmn_if.sv -----
// ----------------------------------------------------------------------------
// tsmn_if: channel interfaces
// Sample input channel, result output channel and configuration write channel,
// each with valid, ready and its word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsmn_in_if import tsmn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SampleW-1:0] sample;
  logic               first_of_set;

  modport source (output valid, kind, sample, first_of_set, input ready);
  modport sink   (input valid, kind, sample, first_of_set, output ready);
endinterface

interface tsmn_out_if import tsmn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              is_mean;
  logic              masked;
  logic              last;

  modport source (output valid, value, is_mean, masked, last, input ready);
  modport sink   (input valid, value, is_mean, masked, last, output ready);
endinterface

interface tsmn_cfg_if import tsmn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/tsmn_div.sv -----
// ----------------------------------------------------------------------------
// tsmn_div: shared saturating divider
// Restoring divider, one quotient bit per cycle. The quotient is limited to
// 24 bits: when the upper numerator bits already reach the divisor, the
// result saturates at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tsmn_div import tsmn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [ValueW-1:0]  rem_q, rem_d;
  logic [ValueW-1:0]  lo_q, lo_d;
  logic [ValueW-1:0]  quo_q, quo_d;
  logic [ValueW-1:0]  den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [ValueW:0]    trial;
  logic               fits;
  logic [ValueW-1:0]  num_hi;

  assign num_hi = ValueW'(req_i.num[NumW-1:ValueW]);
  assign trial  = {rem_q, lo_q[ValueW-1]};
  assign fits   = trial >= {1'b0, den_q};

  // Load, saturation check and one subtract step per cycle.
  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      den_d = req_i.den;
      if (num_hi >= req_i.den) begin
        quo_d  = ValueMax;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = num_hi;
        lo_d   = req_i.num[ValueW-1:0];
        quo_d  = '0;
        cnt_d  = DivSteps;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (fits) begin
        rem_d = ValueW'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[ValueW-1:0];
      end
      quo_d = {quo_q[ValueW-2:0], fits};
      lo_d  = {lo_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// ----- sv/tsmn_store.sv -----
// ----------------------------------------------------------------------------
// tsmn_store: frame buffer
// Single write port, single registered read port holding the samples of the
// current voxel.
// ----------------------------------------------------------------------------
`default_nettype none

module tsmn_store #(
  parameter int unsigned Depth  = 64,
  parameter int unsigned Width  = 16,
  parameter int unsigned AddrW  = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/time_series_mean_normalize_top.sv -----
// ----------------------------------------------------------------------------
// time_series_mean_normalize_top: percent-of-mean voxel normalization
// Survey pass emits one mean per voxel and tracks the range of the means;
// normalize pass emits every frame as a percent of its voxel mean, or masked.
// ----------------------------------------------------------------------------
// Usage: samples arrive on in_i, one word per frame, frames_per_voxel words per
// voxel. Results leave on out_o; configuration writes arrive on cfg_i, which is
// always ready and must only be used while the block is idle.
// A sample that does not complete a voxel is stored and added to the running
// sum. A completing sample starts the mean division in the shared divider,
// which retires one quotient bit per cycle; a survey voxel then emits its mean
// word. A normalize voxel then runs the threshold test in ST_THR_MUL and
// ST_THR_CMP and, per frame, reads its sample and divides it by the mean when
// kept (one division each, ending early when the percent saturates) or emits
// a masked zero.
// in_i is not ready while a voxel is being processed. Results pass through an
// output register; when the receiver stalls, the sequencer waits with the next
// word until the register is free. Reset clears the frame count, running sum,
// mean range, output valid and configuration to their defaults; the frame
// buffer needs no clearing since only entries of the current voxel are read.
// ----------------------------------------------------------------------------
`default_nettype none

module time_series_mean_normalize_top import tsmn_pkg::*; #(
  parameter int unsigned MAX_FRAMES  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsmn_cfg_if.sink   cfg_i,
  tsmn_in_if.sink    in_i,
  tsmn_out_if.source out_o
);

  localparam int unsigned SW    = (SAMPLE_BITS < SampleW) ? SAMPLE_BITS : SampleW;
  localparam int unsigned CntW  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned SumW  = SW + CntW;
  localparam logic [FpvW-1:0] MaxFrm = FpvW'(MAX_FRAMES);

  // Configuration registers.
  logic [FpvW-1:0]   fpv_q;
  logic              norm_q;
  logic [FracW-1:0]  frac_q;
  logic [ValueW-1:0] abs_q;

  // Voxel accumulation and range state.
  logic [CntW-1:0]   idx_q, idx_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [ValueW-1:0] min_q, min_d;
  logic [ValueW-1:0] max_q, max_d;

  // Per-voxel working registers.
  seq_state_e        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              kind_q, kind_d;
  logic [ValueW-1:0] mean_q, mean_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic              keep_q, keep_d;
  logic [CntW-1:0]   k_q, k_d;
  logic [ValueW-1:0] fval_q, fval_d;

  // Output register.
  logic              ovalid_q, ovalid_d;
  logic [ValueW-1:0] oval_q, oval_d;
  logic              omean_q, omean_d;
  logic              omask_q, omask_d;
  logic              olast_q, olast_d;

  // Datapath helpers.
  logic              accept;
  logic              clear_set;
  logic [FpvW-1:0]   eff_frames;
  logic [CntW-1:0]   idx_base, idx_new;
  logic [SumW-1:0]   sum_base, sum_new;
  logic [SW-1:0]     sample_w;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [SW-1:0]     rdata;
  logic              slot_free;
  logic [ValueW-1:0] span;
  logic [ProdW:0]    thr_norm;
  logic [ProdW:0]    mean_wide;
  logic              k_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tsmn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tsmn_store #(
    .Depth (MAX_FRAMES),
    .Width (SW),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (sample_w),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpv_q  <= FpvW'(1);
      norm_q <= 1'b1;
      frac_q <= FracW'(3277);
      abs_q  <= ValueW'(13);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_FRAMES:    fpv_q  <= cfg_i.data[FpvW-1:0];
        CFG_NORM_MODE: norm_q <= cfg_i.data[0];
        CFG_THR_FRAC:  frac_q <= cfg_i.data[FracW-1:0];
        CFG_THR_ABS:   abs_q  <= cfg_i.data[ValueW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame count: zero acts as one, large values are capped.
  always_comb begin
    if (fpv_q == '0) begin
      eff_frames = FpvW'(1);
    end else if (fpv_q > MaxFrm) begin
      eff_frames = MaxFrm;
    end else begin
      eff_frames = fpv_q;
    end
  end

  // Sample intake.
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign clear_set  = !in_i.kind && in_i.first_of_set;
  assign sample_w   = in_i.sample[SW-1:0];
  assign idx_base   = clear_set ? '0 : idx_q;
  assign sum_base   = clear_set ? '0 : sum_q;
  assign idx_new    = idx_base + CntW'(1);
  assign sum_new    = sum_base + SumW'(sample_w);
  assign we         = accept;
  assign waddr      = idx_base[AW-1:0];

  // Threshold arithmetic.
  assign span      = (max_q >= min_q) ? (max_q - min_q) : '0;
  assign thr_norm  = {1'b0, min_q, {FracW{1'b0}}} + (ProdW + 1)'(prod_q);
  assign mean_wide = {1'b0, mean_q, {FracW{1'b0}}};

  assign slot_free = !ovalid_q || out_o.ready;
  assign k_last    = (k_q + CntW'(1)) == count_q;

  // Sequencer: next state, divider requests and output loads.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    min_d    = min_q;
    max_d    = max_q;
    count_d  = count_q;
    kind_d   = kind_q;
    mean_d   = mean_q;
    prod_d   = prod_q;
    keep_d   = keep_q;
    k_d      = k_q;
    fval_d   = fval_q;
    ovalid_d = ovalid_q && !out_o.ready;
    oval_d   = oval_q;
    omean_d  = omean_q;
    omask_d  = omask_q;
    olast_d  = olast_q;
    div_req  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (clear_set) begin
            min_d = ValueMax;
            max_d = '0;
          end
          idx_d = idx_new;
          sum_d = sum_new;
          if (FpvW'(idx_new) >= eff_frames) begin
            count_d       = idx_new;
            kind_d        = in_i.kind;
            idx_d         = '0;
            sum_d         = '0;
            div_req.start = 1'b1;
            div_req.num   = NumW'({sum_new, 8'b0}) + NumW'(idx_new >> 1);
            div_req.den   = ValueW'(idx_new);
            state_d       = ST_MEAN_DIV;
          end
        end
      end

      ST_MEAN_DIV: begin
        if (div_rsp.done) begin
          mean_d  = div_rsp.quo;
          state_d = kind_q ? ST_THR_MUL : ST_MEAN_OUT;
        end
      end

      ST_MEAN_OUT: begin
        if (slot_free) begin
          if (mean_q < min_q) min_d = mean_q;
          if (mean_q > max_q) max_d = mean_q;
          ovalid_d = 1'b1;
          oval_d   = mean_q;
          omean_d  = 1'b1;
          omask_d  = 1'b0;
          olast_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_THR_MUL: begin
        prod_d  = ProdW'(frac_q) * ProdW'(span);
        state_d = ST_THR_CMP;
      end

      ST_THR_CMP: begin
        if (norm_q) begin
          keep_d = (mean_q != '0) && (mean_wide > thr_norm);
        end else begin
          keep_d = (mean_q != '0) && (mean_q > abs_q);
        end
        k_d     = '0;
        state_d = ST_FRM_RD;
      end

      // Read data of the current frame appears in the cycle after its address.
      ST_FRM_RD: begin
        state_d = ST_FRM_LD;
      end

      ST_FRM_LD: begin
        if (keep_q) begin
          div_req.start = 1'b1;
          div_req.num   = ((NumW'(rdata) * PercentScale) << FracW)
                          + NumW'(mean_q >> 1);
          div_req.den   = mean_q;
          state_d       = ST_FRM_DIV;
        end else begin
          fval_d  = '0;
          state_d = ST_FRM_OUT;
        end
      end

      ST_FRM_DIV: begin
        if (div_rsp.done) begin
          fval_d  = div_rsp.quo;
          state_d = ST_FRM_OUT;
        end
      end

      ST_FRM_OUT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          oval_d   = fval_q;
          omean_d  = 1'b0;
          omask_d  = !keep_q;
          olast_d  = k_last;
          if (k_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + CntW'(1);
            state_d = ST_FRM_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and range state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      sum_q    <= '0;
      min_q    <= ValueMax;
      max_q    <= '0;
      ovalid_q <= 1'b0;
      count_q  <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      min_q    <= min_d;
      max_q    <= max_d;
      ovalid_q <= ovalid_d;
      count_q  <= count_d;
      k_q      <= k_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    mean_q  <= mean_d;
    prod_q  <= prod_d;
    keep_q  <= keep_d;
    fval_q  <= fval_d;
    oval_q  <= oval_d;
    omean_q <= omean_d;
    omask_q <= omask_d;
    olast_q <= olast_d;
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.value   = oval_q;
  assign out_o.is_mean = omean_q;
  assign out_o.masked  = omask_q;
  assign out_o.last    = olast_q;

endmodule

`default_nettype wire
